// ===== rtl/mandelbrot_escape_time_pixel_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel engine checks
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH

// consequent in the cycle after the antecedent
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the same cycle
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Widths, constants, types and helpers of the escape-time pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = COORD_BITS - 6;
  localparam int PIXEL_BITS = 12;
  localparam int DIM_BITS   = PIXEL_BITS + 1;
  localparam int ITER_BITS  = 16;
  localparam int GRAY_BITS  = 8;
  localparam int GRAY_TOP   = 255;
  localparam int ESC_RADIUS_SQ = 4;

  localparam int SPAN_BITS = COORD_BITS + 1;
  localparam int NUM_BITS  = PIXEL_BITS + SPAN_BITS;
  localparam int DIVS_BITS = (DIM_BITS > ITER_BITS) ? DIM_BITS : ITER_BITS;
  localparam int PROD_BITS = 2 * COORD_BITS;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COORD_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_X_MIN    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_X_MAX    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_MIN    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_MAX    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PIX_COLS = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PIX_ROWS = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER = 3'd6;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [PROD_BITS-1:0] WIDE_MAX = PROD_BITS'(COORD_MAX);
  localparam logic signed [PROD_BITS-1:0] WIDE_MIN = PROD_BITS'(COORD_MIN);

  // |z|^2 bound of 4.0 in the coordinate format, one bit wider than a coordinate
  localparam logic signed [COORD_BITS:0] ESC_LIMIT =
    (COORD_BITS+1)'(ESC_RADIUS_SQ) << FRAC_BITS;

  // mapping quotient is capped at 2^COORD_BITS before the sign goes on
  localparam logic [COORD_BITS:0] Q_CAP = {1'b1, {COORD_BITS{1'b0}}};

  localparam coord_t RST_LO = -(coord_t'(ESC_RADIUS_SQ) <<< FRAC_BITS);
  localparam coord_t RST_HI = coord_t'(ESC_RADIUS_SQ) <<< FRAC_BITS;
  localparam logic [DIM_BITS-1:0]  RST_DIM  = DIM_BITS'(500);
  localparam logic [ITER_BITS-1:0] RST_ITER = ITER_BITS'(1000);

  typedef struct packed {
    coord_t                x_min;
    coord_t                x_max;
    coord_t                y_min;
    coord_t                y_max;
    logic [DIM_BITS-1:0]   pix_cols;
    logic [DIM_BITS-1:0]   pix_rows;
    logic [ITER_BITS-1:0]  max_iter;
  } mbe_cfg_t;

  typedef struct packed {
    logic                  start;
    logic [NUM_BITS-1:0]   dividend;
    logic [DIVS_BITS-1:0]  divisor;
  } mbe_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [NUM_BITS-1:0]   quotient;
  } mbe_div_rsp_t;

  typedef struct packed {
    logic                  valid;
    logic [ITER_BITS-1:0]  escape_count;
    logic [GRAY_BITS-1:0]  gray_level;
  } mbe_res_t;

  function automatic coord_t sat_coord(input logic signed [PROD_BITS-1:0] v);
    coord_t r;
    if (v > WIDE_MAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbe_if.sv =====
// ----------------------------------------------------------------------------
// mbe_if
// Valid/ready channels: pixel words in, escape-time result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_pixel_if import mbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_col;
  logic [PIXEL_BITS-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_result_if import mbe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ITER_BITS-1:0] escape_count;
  logic [GRAY_BITS-1:0] gray_level;

  modport source (output valid, output escape_count, output gray_level, input ready);
  modport sink   (input valid, input escape_count, input gray_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbe_div.sv =====
// ----------------------------------------------------------------------------
// mbe_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_div import mbe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  mbe_div_req_t req,
  output mbe_div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [DIVS_BITS-1:0] rem;
  logic [DIVS_BITS-1:0] dvs;
  logic [NUM_BITS-1:0]  quo;

  logic [DIVS_BITS:0]   trial;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[NUM_BITS-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // dividend shifts out of quo at the top as quotient bits shift in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= CNT_BITS'(NUM_BITS);
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      cnt <= cnt - CNT_BITS'(1);
      if (fits) begin
        rem <= DIVS_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIVS_BITS-1:0];
      end
      quo <= {quo[NUM_BITS-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/mbe_core.sv =====
// ----------------------------------------------------------------------------
// mbe_core
// Sequencer and datapath: coordinate mapping, z = z*z + c loop, gray level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_core import mbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  mbe_cfg_t              cfg,
  input  logic                  in_valid,
  input  logic [PIXEL_BITS-1:0] in_col,
  input  logic [PIXEL_BITS-1:0] in_row,
  output logic                  in_ready,
  output mbe_res_t              res,
  input  logic                  res_take
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_MAP_MUL    = 11'b00000000010,
    S_MAP_DIV    = 11'b00000000100,
    S_MAP_ADD    = 11'b00000001000,
    S_IT_XX      = 11'b00000010000,
    S_IT_YY      = 11'b00000100000,
    S_IT_XY      = 11'b00001000000,
    S_IT_UPD     = 11'b00010000000,
    S_GRAY_START = 11'b00100000000,
    S_GRAY_DIV   = 11'b01000000000,
    S_DONE       = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [PIXEL_BITS-1:0] col, row;
  logic                  sel_y;
  logic                  span_neg;
  logic                  div_zero;
  coord_t                cx, cy, zx, zy, xx, yy;
  logic signed [PROD_BITS-1:0] prod;
  logic [ITER_BITS-1:0]  count;
  logic [GRAY_BITS-1:0]  gray;

  mbe_div_req_t div_req;
  mbe_div_rsp_t div_rsp;

  coord_t                map_lo, map_hi;
  logic [PIXEL_BITS-1:0] map_idx;
  logic [DIM_BITS-1:0]   map_div;
  logic signed [SPAN_BITS-1:0] span;
  logic [SPAN_BITS-1:0]  uspan;
  logic [NUM_BITS-1:0]   map_num;
  logic [NUM_BITS-1:0]   gray_num;
  logic [COORD_BITS:0]   qc;
  logic signed [PROD_BITS-1:0] off;
  coord_t                map_coord;

  coord_t                mul_a, mul_b;
  logic signed [PROD_BITS-1:0] mul_p;
  coord_t                sq;
  coord_t                xy2;
  logic signed [COORD_BITS:0] mag;
  logic                  escape;
  logic                  at_limit;
  coord_t                zx_new, zy_new;

  mbe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---- mapping ----
  always_comb begin
    map_lo  = sel_y ? cfg.y_min : cfg.x_min;
    map_hi  = sel_y ? cfg.y_max : cfg.x_max;
    map_idx = sel_y ? row : col;
    map_div = sel_y ? cfg.pix_rows : cfg.pix_cols;
    span    = SPAN_BITS'(map_hi) - SPAN_BITS'(map_lo);
    uspan   = span[SPAN_BITS-1] ? unsigned'(-span) : unsigned'(span);
    map_num = NUM_BITS'(map_idx) * NUM_BITS'(uspan);
    gray_num = NUM_BITS'(count) * NUM_BITS'(GRAY_TOP);

    if (div_zero) begin
      qc = '0;
    end else if (div_rsp.quotient > NUM_BITS'(Q_CAP)) begin
      qc = Q_CAP;
    end else begin
      qc = div_rsp.quotient[COORD_BITS:0];
    end
    off = signed'(PROD_BITS'(qc));
    if (span_neg) begin
      off = -off;
    end
    map_coord = sat_coord(PROD_BITS'(map_lo) + off);
  end

  always_comb begin
    div_req.start    = (state == S_MAP_MUL) || (state == S_GRAY_START);
    div_req.dividend = (state == S_GRAY_START) ? gray_num : map_num;
    div_req.divisor  = (state == S_GRAY_START) ? DIVS_BITS'(cfg.max_iter)
                                               : DIVS_BITS'(map_div);
  end

  // ---- shared multiplier: zx*zx, zy*zy, zx*zy in turn ----
  always_comb begin
    mul_a  = (state == S_IT_YY) ? zy : zx;
    mul_b  = (state == S_IT_XX) ? zx : zy;
    mul_p  = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    sq     = sat_coord(prod >>> FRAC_BITS);
    // one bit less of shift doubles the cross term
    xy2    = sat_coord(prod >>> (FRAC_BITS - 1));
    mag    = (COORD_BITS+1)'(xx) + (COORD_BITS+1)'(yy);
    escape = (mag > ESC_LIMIT);
    at_limit = (count >= cfg.max_iter);
    zx_new = sat_coord(PROD_BITS'(xx) - PROD_BITS'(yy) + PROD_BITS'(cx));
    zy_new = sat_coord(PROD_BITS'(xy2) + PROD_BITS'(cy));
  end

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (in_valid) state_next = S_MAP_MUL;
      S_MAP_MUL:    state_next = S_MAP_DIV;
      S_MAP_DIV:    if (div_rsp.done) state_next = S_MAP_ADD;
      S_MAP_ADD:    state_next = sel_y ? S_IT_XX : S_MAP_MUL;
      S_IT_XX:      state_next = at_limit ? S_GRAY_START : S_IT_YY;
      S_IT_YY:      state_next = S_IT_XY;
      S_IT_XY:      state_next = S_IT_UPD;
      S_IT_UPD:     state_next = escape ? S_GRAY_START : S_IT_XX;
      S_GRAY_START: state_next = S_GRAY_DIV;
      S_GRAY_DIV:   if (div_rsp.done) state_next = S_DONE;
      S_DONE:       if (res_take) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel_y <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        sel_y <= 1'b0;
      end else if (state == S_MAP_ADD) begin
        sel_y <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col   <= in_col;
        row   <= in_row;
        count <= '0;
      end
      S_MAP_MUL: begin
        span_neg <= span[SPAN_BITS-1];
        div_zero <= (map_div == '0);
      end
      S_MAP_ADD: begin
        if (sel_y) begin
          cy <= map_coord;
          zy <= map_coord;
        end else begin
          cx <= map_coord;
          zx <= map_coord;
        end
      end
      S_IT_XX: prod <= mul_p;
      S_IT_YY: begin
        xx   <= sq;
        prod <= mul_p;
      end
      S_IT_XY: begin
        yy   <= sq;
        prod <= mul_p;
      end
      S_IT_UPD: begin
        if (!escape) begin
          zx    <= zx_new;
          zy    <= zy_new;
          count <= count + ITER_BITS'(1);
        end
      end
      S_GRAY_DIV: begin
        // limit of zero: count stays 0 and the gray level is 0
        if (cfg.max_iter == '0) begin
          gray <= '0;
        end else begin
          gray <= div_rsp.quotient[GRAY_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready         = (state == S_IDLE);
  assign res.valid        = (state == S_DONE);
  assign res.escape_count = count;
  assign res.gray_level   = gray;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time engine for one pixel: maps column/row to c, iterates z*z + c,
// returns the iteration count and a gray level.
// ----------------------------------------------------------------------------
//  channel  | dir | word fields                      | handshake
//  ---------+-----+----------------------------------+--------------------
//  pixel    | in  | pixel_col[11:0], pixel_row[11:0] | valid/ready
//  result   | out | escape_count[15:0], gray_level   | valid/ready
//  cfg      | in  | cfg_index[2:0], cfg_data[31:0]   | cfg_write, no wait
//
//  Coordinates are Q6.26. Mapping divides once per axis; each iteration
//  steps through S_IT_XX, S_IT_YY, S_IT_XY and S_IT_UPD; the gray level
//  divides once. The shared 32x32 multiplier (3 uses per iteration) and
//  the bit-serial divider, shared by both axes and gray, set the pace.
//  One pixel at a time; a finished word waits in the output register while
//  the next pixel is taken. Reset is synchronous and restores the
//  configuration registers and all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel import mbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  mbe_pixel_if.sink                 pixel,
  mbe_result_if.source              result,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  mbe_cfg_t cfg;
  mbe_res_t core_res;
  logic     res_take;
  logic     out_valid;
  logic [ITER_BITS-1:0] out_count;
  logic [GRAY_BITS-1:0] out_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min    <= RST_LO;
      cfg.x_max    <= RST_HI;
      cfg.y_min    <= RST_LO;
      cfg.y_max    <= RST_HI;
      cfg.pix_cols <= RST_DIM;
      cfg.pix_rows <= RST_DIM;
      cfg.max_iter <= RST_ITER;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_X_MIN:    cfg.x_min    <= coord_t'(cfg_data[COORD_BITS-1:0]);
        CFG_X_MAX:    cfg.x_max    <= coord_t'(cfg_data[COORD_BITS-1:0]);
        CFG_Y_MIN:    cfg.y_min    <= coord_t'(cfg_data[COORD_BITS-1:0]);
        CFG_Y_MAX:    cfg.y_max    <= coord_t'(cfg_data[COORD_BITS-1:0]);
        CFG_PIX_COLS: cfg.pix_cols <= cfg_data[DIM_BITS-1:0];
        CFG_PIX_ROWS: cfg.pix_rows <= cfg_data[DIM_BITS-1:0];
        CFG_MAX_ITER: cfg.max_iter <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  mbe_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (pixel.valid),
    .in_col   (pixel.pixel_col),
    .in_row   (pixel.pixel_row),
    .in_ready (pixel.ready),
    .res      (core_res),
    .res_take (res_take)
  );

  // output register: loads whenever it is empty or being drained
  assign res_take = core_res.valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_count <= core_res.escape_count;
      out_gray  <= core_res.gray_level;
    end
  end

  assign result.valid        = out_valid;
  assign result.escape_count = out_count;
  assign result.gray_level   = out_gray;

endmodule

`default_nettype wire

// ===== rtl/mbe_checker.sv =====
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the escape-time pixel engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_time_pixel_assert.svh"

module mbe_checker import mbe_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 pixel_valid,
  input logic                 pixel_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [ITER_BITS-1:0] escape_count,
  input logic [GRAY_BITS-1:0] gray_level
);

  // a stalled result word holds
  `MBE_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(escape_count) && $stable(gray_level), "result word changed while stalled")

  // one pixel at a time: busy straight after a pixel word is taken
  `MBE_ASSERT_NEXT(a_busy_after_accept, pixel_valid && pixel_ready, !pixel_ready, "pixel taken while busy")

  // mapping must finish first, so no result can appear right after a take
  `MBE_ASSERT_NEXT(a_no_instant_result, pixel_valid && pixel_ready && !result_valid, !result_valid, "result appeared without work")

  // zero iterations give black
  `MBE_ASSERT_NOW(a_gray_zero, result_valid && escape_count == '0, gray_level == '0, "gray level non-zero for zero count")

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_mbe_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel.valid),
  .pixel_ready  (pixel.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .escape_count (result.escape_count),
  .gray_level   (result.gray_level)
);

`default_nettype wire

// ===== bench/mandelbrot_escape_time_pixel_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_tb
// Self-checking bench for the escape-time pixel engine. A directed table covers
// reset values, extreme windows, zero divisors and iteration limits. Random
// phases then reprogram the window and send pixels with random gaps on both
// channels. Words are compared with the table or a fixed-point model kept here.
// ----------------------------------------------------------------------------

module mandelbrot_escape_time_pixel_tb import mbe_pkg::*;;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 2000;
  localparam int unsigned LONG_HOLD     = 3000;
  localparam int unsigned IDLE_LIMIT    = 800000;
  localparam int unsigned REPORT_CAP    = 40;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 60;

  // random windows: x from -2.5, y from -1.5, reach and span up to 3.0 / 2.0
  localparam int unsigned X_BASE  = 32'd167772160;
  localparam int unsigned X_REACH = 32'd201326592;
  localparam int unsigned Y_BASE  = 32'd100663296;
  localparam int unsigned Y_REACH = 32'd134217728;
  localparam int unsigned MIN_SPAN = 32'h0000_4000;

  localparam longint ESCAPE_BOUND = longint'(ESC_RADIUS_SQ) <<< FRAC_BITS;
  localparam longint AXIS_CAP     = longint'(1) <<< COORD_BITS;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] col;
    logic [PIXEL_BITS-1:0] row;
    logic [ITER_BITS-1:0]  escape_count;
    logic [GRAY_BITS-1:0]  gray_level;
  } escape_word_t;

  typedef enum logic [1:0] {STEP_WRITE, STEP_PIXEL, STEP_PIXEL_KNOWN} step_kind_t;

  typedef struct packed {
    step_kind_t                kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [PIXEL_BITS-1:0]     col;
    logic [PIXEL_BITS-1:0]     row;
    logic [ITER_BITS-1:0]      count;
    logic [GRAY_BITS-1:0]      gray;
  } step_t;

  localparam int PLAN_LEN = 44;
  localparam step_t DIRECTED_PLAN [PLAN_LEN] = '{
    // reset window -4..4 on both axes, 500x500, limit 1000
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd0,    12'd0,    16'd0,     8'd0},
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd250,  12'd250,  16'd1000,  8'd255},
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd4095, 12'd4095, 16'd0,     8'd0},
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd250,  12'd0,    16'd0,     8'd0},
    '{STEP_PIXEL,       '0, '0, 12'd125,  12'd375,  '0,        '0},
    '{STEP_WRITE, CFG_MAX_ITER, 32'd0,         '0, '0, '0, '0},
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd250,  12'd250,  16'd0,     8'd0},
    '{STEP_WRITE, CFG_MAX_ITER, 32'd1,         '0, '0, '0, '0},
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd250,  12'd250,  16'd1,     8'd255},
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd0,    12'd0,    16'd0,     8'd0},
    '{STEP_WRITE, CFG_MAX_ITER, 32'd65535,     '0, '0, '0, '0},
    '{STEP_PIXEL_KNOWN, '0, '0, 12'd250,  12'd250,  16'd65535, 8'd255},
    // zero divisors pin c to the minimum corner
    '{STEP_WRITE, CFG_MAX_ITER, 32'd100,       '0, '0, '0, '0},
    '{STEP_WRITE, CFG_PIX_COLS, 32'd0,         '0, '0, '0, '0},
    '{STEP_WRITE, CFG_PIX_ROWS, 32'd0,         '0, '0, '0, '0},
    '{STEP_WRITE, CFG_X_MIN,    32'hFE00_0000, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_Y_MIN,    32'h0000_0000, '0, '0, '0, '0},
    '{STEP_PIXEL,       '0, '0, 12'd4095, 12'd17,   '0,        '0},
    '{STEP_PIXEL,       '0, '0, 12'd0,    12'd0,    '0,        '0},
    // reversed x bounds, step runs negative
    '{STEP_WRITE, CFG_X_MIN,    32'h0800_0000, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_X_MAX,    32'hF800_0000, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_Y_MIN,    32'hF800_0000, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_Y_MAX,    32'h0800_0000, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_PIX_COLS, 32'd4096,      '0, '0, '0, '0},
    '{STEP_WRITE, CFG_PIX_ROWS, 32'd4096,      '0, '0, '0, '0},
    '{STEP_PIXEL,       '0, '0, 12'd2048, 12'd2048, '0,        '0},
    '{STEP_PIXEL,       '0, '0, 12'd4095, 12'd0,    '0,        '0},
    '{STEP_PIXEL,       '0, '0, 12'd1000, 12'd3000, '0,        '0},
    // full coordinate range, widest divisor with junk above its bits
    '{STEP_WRITE, CFG_X_MIN,    COORD_MIN,     '0, '0, '0, '0},
    '{STEP_WRITE, CFG_X_MAX,    COORD_MAX,     '0, '0, '0, '0},
    '{STEP_WRITE, CFG_Y_MIN,    COORD_MAX,     '0, '0, '0, '0},
    '{STEP_WRITE, CFG_Y_MAX,    COORD_MIN,     '0, '0, '0, '0},
    '{STEP_WRITE, CFG_PIX_COLS, 32'hFFFF_FFFF, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_PIX_ROWS, 32'd1,         '0, '0, '0, '0},
    '{STEP_PIXEL,       '0, '0, 12'd4095, 12'd4095, '0,        '0},
    '{STEP_PIXEL,       '0, '0, 12'd0,    12'd0,    '0,        '0},
    '{STEP_PIXEL,       '0, '0, 12'd4095, 12'd0,    '0,        '0},
    '{STEP_PIXEL,       '0, '0, 12'd2048, 12'd0,    '0,        '0},
    '{STEP_WRITE, CFG_PIX_COLS, 32'd1,         '0, '0, '0, '0},
    '{STEP_WRITE, CFG_PIX_ROWS, 32'h0000_1FFF, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_X_MIN,    32'h0000_0000, '0, '0, '0, '0},
    '{STEP_WRITE, CFG_X_MAX,    32'h0000_0000, '0, '0, '0, '0},
    '{STEP_PIXEL,       '0, '0, 12'd0,    12'd4095, '0,        '0},
    '{STEP_PIXEL,       '0, '0, 12'd4095, 12'd2048, '0,        '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mbe_pixel_if  pixel_bus ();
  mbe_result_if result_bus ();

  mandelbrot_escape_time_pixel u_top (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel_bus),
    .result    (result_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  mbe_cfg_t     live_cfg;
  escape_word_t escape_words_due [$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           send_calm = 1'b0;

  // ---------------- fixed-point model ----------------

  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // exact product, floor shift, clamp
  function automatic coord_t fixed_mul(input coord_t a, input coord_t b, input int sh);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_coord(p >>> sh);
  endfunction

  // quotient truncates toward zero: magnitude divided, sign put back after
  function automatic coord_t pixel_to_axis(input coord_t lo, input coord_t hi,
                                           input logic [PIXEL_BITS-1:0] idx,
                                           input logic [DIM_BITS-1:0] dim);
    longint span, mag, pixels, steps, q;
    span   = longint'(hi) - longint'(lo);
    mag    = (span < 0) ? -span : span;
    pixels = idx;
    steps  = dim;
    if (dim == '0) return lo;
    q = (pixels * mag) / steps;
    if (q > AXIS_CAP) q = AXIS_CAP;
    return clamp_coord(longint'(lo) + ((span < 0) ? -q : q));
  endfunction

  function automatic escape_word_t escape_time_of(input logic [PIXEL_BITS-1:0] col,
                                                  input logic [PIXEL_BITS-1:0] row);
    coord_t       cx, cy, zx, zy, xx, yy, xy2;
    int unsigned  n;
    escape_word_t w;
    cx = pixel_to_axis(live_cfg.x_min, live_cfg.x_max, col, live_cfg.pix_cols);
    cy = pixel_to_axis(live_cfg.y_min, live_cfg.y_max, row, live_cfg.pix_rows);
    zx = cx;
    zy = cy;
    n  = 0;
    while (n < live_cfg.max_iter) begin
      xx = fixed_mul(zx, zx, FRAC_BITS);
      yy = fixed_mul(zy, zy, FRAC_BITS);
      if (longint'(xx) + longint'(yy) > ESCAPE_BOUND) break;
      // one bit less of shift gives 2*zx*zy
      xy2 = fixed_mul(zx, zy, FRAC_BITS - 1);
      zx  = clamp_coord(longint'(xx) - longint'(yy) + longint'(cx));
      zy  = clamp_coord(longint'(xy2) + longint'(cy));
      n++;
    end
    w.col          = col;
    w.row          = row;
    w.escape_count = n[ITER_BITS-1:0];
    w.gray_level   = (live_cfg.max_iter == '0) ? '0
                   : GRAY_BITS'((GRAY_TOP * n) / live_cfg.max_iter);
    return w;
  endfunction

  // ---------------- drivers ----------------

  function automatic int unsigned pick_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_X_MIN:    live_cfg.x_min    = coord_t'(data);
      CFG_X_MAX:    live_cfg.x_max    = coord_t'(data);
      CFG_Y_MIN:    live_cfg.y_min    = coord_t'(data);
      CFG_Y_MAX:    live_cfg.y_max    = coord_t'(data);
      CFG_PIX_COLS: live_cfg.pix_cols = data[DIM_BITS-1:0];
      CFG_PIX_ROWS: live_cfg.pix_rows = data[DIM_BITS-1:0];
      CFG_MAX_ITER: live_cfg.max_iter = data[ITER_BITS-1:0];
      default: ;
    endcase
  endtask

  // drop valid, then wait for every word in flight to come back
  task automatic wait_engine_idle();
    @(negedge clk);
    pixel_bus.valid <= 1'b0;
    cfg_write       <= 1'b0;
    while (escape_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid stays high from the previous word unless a gap is drawn
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] col,
                            input logic [PIXEL_BITS-1:0] row,
                            input bit known, input escape_word_t given);
    int unsigned gap;
    gap = pick_gap(send_calm);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (gap != 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_bus.valid     <= 1'b1;
    pixel_bus.pixel_col <= col;
    pixel_bus.pixel_row <= row;
    @(posedge clk);
    while (!pixel_bus.ready) @(posedge clk);
    escape_words_due.push_back(known ? given : escape_time_of(col, row));
  endtask

  // ---------------- random phases ----------------

  task automatic draw_window(input int unsigned base, input int unsigned reach,
                             output coord_t lo, output coord_t hi);
    coord_t t;
    if ($urandom_range(0, 7) == 0) begin
      lo = coord_t'($urandom);
      hi = coord_t'($urandom);
    end else begin
      lo = coord_t'($urandom_range(0, reach)) - coord_t'(base);
      hi = lo + coord_t'($urandom_range(MIN_SPAN, reach));
    end
    if ($urandom_range(0, 5) == 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
  endtask

  function automatic logic [DIM_BITS-1:0] draw_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DIM_BITS'(4096);
      3:       return DIM_BITS'(1);
      4:       return DIM_BITS'($urandom);
      default: return DIM_BITS'($urandom_range(2, 600));
    endcase
  endfunction

  // mostly inside the image, now and then anywhere
  function automatic logic [PIXEL_BITS-1:0] draw_pixel(input logic [DIM_BITS-1:0] dim);
    int unsigned top;
    top = (dim > 4096) ? 4096 : dim;
    if (top == 0 || $urandom_range(0, 6) == 0) return PIXEL_BITS'($urandom);
    return PIXEL_BITS'($urandom_range(0, top - 1));
  endfunction

  function automatic logic [ITER_BITS-1:0] draw_limit();
    case ($urandom_range(0, 11))
      0:       return '0;
      1, 2:    return ITER_BITS'($urandom_range(65, 300));
      default: return ITER_BITS'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned items);
    coord_t                   lo, hi;
    logic [DIM_BITS-1:0]      cols, rows;
    logic [ITER_BITS-1:0]     limit;
    logic [CFG_DATA_BITS-1:0] junk;
    escape_word_t             no_given;
    no_given = '0;
    wait_engine_idle();
    draw_window(X_BASE, X_REACH, lo, hi);
    write_reg(CFG_X_MIN, lo);
    write_reg(CFG_X_MAX, hi);
    draw_window(Y_BASE, Y_REACH, lo, hi);
    write_reg(CFG_Y_MIN, lo);
    write_reg(CFG_Y_MAX, hi);
    // upper data bits carry junk half the time; only the register width counts
    cols = draw_dim();
    junk = $urandom;
    write_reg(CFG_PIX_COLS,
              junk[0] ? {junk[CFG_DATA_BITS-1:DIM_BITS], cols} : CFG_DATA_BITS'(cols));
    rows = draw_dim();
    junk = $urandom;
    write_reg(CFG_PIX_ROWS,
              junk[0] ? {junk[CFG_DATA_BITS-1:DIM_BITS], rows} : CFG_DATA_BITS'(rows));
    limit = draw_limit();
    junk  = $urandom;
    write_reg(CFG_MAX_ITER,
              junk[0] ? {junk[CFG_DATA_BITS-1:ITER_BITS], limit} : CFG_DATA_BITS'(limit));
    repeat (items) send_pixel(draw_pixel(cols), draw_pixel(rows), 1'b0, no_given);
  endtask

  // ---------------- stimulus ----------------

  initial begin : pixel_side
    escape_word_t given;
    cfg_write           = 1'b0;
    cfg_index           = CFG_X_MIN;
    cfg_data            = '0;
    pixel_bus.valid     = 1'b0;
    pixel_bus.pixel_col = '0;
    pixel_bus.pixel_row = '0;
    live_cfg.x_min    = RST_LO;
    live_cfg.x_max    = RST_HI;
    live_cfg.y_min    = RST_LO;
    live_cfg.y_max    = RST_HI;
    live_cfg.pix_cols = RST_DIM;
    live_cfg.pix_rows = RST_DIM;
    live_cfg.max_iter = RST_ITER;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (DIRECTED_PLAN[i].kind == STEP_WRITE) begin
        wait_engine_idle();
        write_reg(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].data);
      end else begin
        given.col          = DIRECTED_PLAN[i].col;
        given.row          = DIRECTED_PLAN[i].row;
        given.escape_count = DIRECTED_PLAN[i].count;
        given.gray_level   = DIRECTED_PLAN[i].gray;
        send_pixel(DIRECTED_PLAN[i].col, DIRECTED_PLAN[i].row,
                   DIRECTED_PLAN[i].kind == STEP_PIXEL_KNOWN, given);
      end
    end

    repeat (PHASES) run_random_phase(PHASE_ITEMS);

    wait_engine_idle();
    // anything turning up now has no word due and is flagged
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("mandelbrot_escape_time_pixel_tb: clean");
    end else begin
      $display("mandelbrot_escape_time_pixel_tb: errors");
    end
    $finish;
  end

  // ---------------- result checking ----------------

  initial begin : result_side
    escape_word_t due;
    int unsigned  gap;
    int unsigned  words_seen;
    bit           calm;
    result_bus.ready = 1'b0;
    words_seen = 0;
    calm       = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = pick_gap(calm);
      // long hold so the engine backs up onto the pixel channel
      if (words_seen % 250 == 60) gap = LONG_HOLD;
      @(negedge clk);
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
      words_seen++;
      if (escape_words_due.size() == 0) begin
        flag_mismatch($sformatf("word with nothing due: count %0d gray %0d",
                                result_bus.escape_count, result_bus.gray_level));
      end else begin
        due = escape_words_due.pop_front();
        if (result_bus.escape_count !== due.escape_count)
          flag_mismatch($sformatf("pixel (%0d,%0d) escape_count %0d, want %0d",
                                  due.col, due.row, result_bus.escape_count,
                                  due.escape_count));
        if (result_bus.gray_level !== due.gray_level)
          flag_mismatch($sformatf("pixel (%0d,%0d) gray_level %0d, want %0d",
                                  due.col, due.row, result_bus.gray_level,
                                  due.gray_level));
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst || (pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("[%0t] no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("mandelbrot_escape_time_pixel_tb: errors");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_if.sv
rtl/mbe_div.sv
rtl/mbe_core.sv
rtl/mandelbrot_escape_time_pixel.sv
rtl/mbe_checker.sv
bench/mandelbrot_escape_time_pixel_tb.sv
